// ----- hw/rtl/mtga_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and the restoring-division step of the mosaic gather address generator.
package mtga_pkg;

    localparam int MAX_CELLS        = 4096;
    localparam int TILE_NUMBER_BITS = 12;
    localparam int CELL_W           = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

    localparam int COORD_W     = 12;
    localparam int GRID_W      = 7;
    localparam int DTILE_W     = 9;
    localparam int CFG_DATA_W  = 9;
    localparam int CFG_INDEX_W = 2;
    localparam int REM_W       = 6;
    localparam int GQ_W        = 6;
    localparam int CELLSUM_W   = 13;
    localparam int SIDE_W      = 13;
    localparam int DD_W        = 17;
    localparam int PROD_W      = 14;
    localparam int FRAC_W      = 8;
    localparam int SRC_W       = 28;
    localparam int MOS_W       = 24;
    localparam int DIV_STAGES  = COORD_W;
    localparam int FRAC_STAGES = FRAC_W;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_MAP  = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_GRID_SIDE    = 2'd0,
        CFG_SMALL_TILE   = 2'd1,
        CFG_DATASET_TILE = 2'd2
    } cfg_index_t;

    typedef logic [TILE_NUMBER_BITS-1:0] tile_num_t;
    typedef logic [CELL_W-1:0]           cell_addr_t;
    typedef logic [SRC_W-1:0]            src_t;

    typedef struct packed {
        logic [GRID_W-1:0]    grid;
        logic [GRID_W-1:0]    stile;
        logic [DTILE_W-1:0]   dtile;
        logic [CELLSUM_W-1:0] cells;
        logic [SIDE_W-1:0]    side;
        logic [DD_W-1:0]      dd;
    } cfg_t;

    typedef struct packed {
        logic             was_map;
        logic [SRC_W-1:0] src;
        logic [MOS_W-1:0] mos;
        logic             oor;
    } res_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic             q;
    } step_t;

    function automatic step_t div_step(input logic [REM_W-1:0] rem, input logic din,
                                       input logic [GRID_W-1:0] divisor);
        logic [REM_W:0] shifted;
        logic [REM_W:0] diff;
        step_t          r;
        shifted = {rem, din};
        diff    = shifted - divisor;
        if (shifted >= divisor)
        begin
            r.rem = diff[REM_W-1:0];
            r.q   = 1'b1;
        end
        else
        begin
            r.rem = shifted[REM_W-1:0];
            r.q   = 1'b0;
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/mosaic_tile_gather_address.sv -----
`timescale 1ns / 1ps
// Top level of the mosaic gather address generator: address pipeline around the order table.
//
// Input channel (in_valid / in_stall): a transaction with cmd = 0 loads order_slot of the
// order table with tile_number; cmd = 1 maps output pixel (out_x, out_y). Every transaction
// yields exactly one result transaction on the output channel (out_valid / out_stall), in
// order: a load acknowledge (was_map = 0) or a map result with source_address and
// mosaic_address. out_of_range flags a load slot or a coordinate outside the grid.
// Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) sets grid_side, small_tile and
// dataset_tile; write it only while no transaction is in flight.
// Throughput is one transaction per cycle while in_stall is low. Each transaction passes
// through two pipelined restoring dividers by small_tile (12 stages for the grid split,
// 8 stages for the tile scaling) and the single order table port, which serves one load
// write or one lookup per cycle while the pipeline advances, in transaction order.
// Reset clears the pipeline and returns the configuration to 8, 16 and 16 tiles/pixels; the
// order table holds no defined contents until loaded.
// When the receiver stalls, the result holds, one more result moves into a skid entry, and
// in_stall rises until the skid entry drains.
module mosaic_tile_gather_address (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  cmd,
    input  logic [11:0]                           order_slot,
    input  logic [11:0]                           tile_number,
    input  logic [11:0]                           out_x,
    input  logic [11:0]                           out_y,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  was_map,
    output logic [27:0]                           source_address,
    output logic [23:0]                           mosaic_address,
    output logic                                  out_of_range,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [mtga_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [mtga_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int DS = mtga_pkg::DIV_STAGES;
    localparam int FS = mtga_pkg::FRAC_STAGES;
    localparam int TB = mtga_pkg::TILE_NUMBER_BITS;

    mtga_pkg::cfg_t cfg;
    logic           adv;
    logic           skid_full;

    // input register
    logic        p0_valid_reg;
    logic        p0_cmd_reg;
    logic [11:0] p0_slot_reg;
    logic [11:0] p0_tile_reg;
    logic [11:0] p0_x_reg;
    logic [11:0] p0_y_reg;

    // range check and mosaic product
    logic                  a_valid_reg;
    logic                  a_cmd_reg;
    logic [11:0]           a_slot_reg;
    mtga_pkg::tile_num_t   a_tile_reg;
    logic [11:0]           a_x_reg;
    logic [11:0]           a_y_reg;
    logic                  a_oor_reg;
    logic                  a_oor_next;
    logic [23:0]           a_mos_reg;
    logic [24:0]           mos_prod;

    // grid split dividers
    logic [DS-1:0]         d_valid_reg;
    logic                  d_cmd_reg  [DS];
    logic                  d_oor_reg  [DS];
    logic [11:0]           d_slot_reg [DS];
    mtga_pkg::tile_num_t   d_tile_reg [DS];
    logic [23:0]           d_mos_reg  [DS];
    logic [11:0]           d_xw_reg   [DS];
    logic [11:0]           d_yw_reg   [DS];
    logic [5:0]            d_xr_reg   [DS];
    logic [5:0]            d_yr_reg   [DS];
    logic [11:0]           d_xw_next  [DS];
    logic [11:0]           d_yw_next  [DS];
    logic [5:0]            d_xr_next  [DS];
    logic [5:0]            d_yr_next  [DS];

    // cell index and offset products
    logic                  c_valid_reg;
    logic                  c_cmd_reg;
    logic                  c_oor_reg;
    logic [11:0]           c_slot_reg;
    mtga_pkg::tile_num_t   c_tile_reg;
    logic [23:0]           c_mos_reg;
    logic [12:0]           c_cell_reg;
    logic [12:0]           c_cell_next;
    logic [13:0]           c_px_reg;
    logic [13:0]           c_py_reg;
    logic [13:0]           c_px_next;
    logic [13:0]           c_py_next;
    logic [5:0]            qx;
    logic [5:0]            qy;

    // order table access
    logic                  m_valid_reg;
    logic                  m_cmd_reg;
    logic                  m_oor_reg;
    logic [23:0]           m_mos_reg;
    logic [13:0]           m_px_reg;
    logic [13:0]           m_py_reg;
    logic                  ram_we;
    mtga_pkg::cell_addr_t  ram_addr;
    mtga_pkg::tile_num_t   ram_rdata;

    // tile scaling dividers
    logic [FS-1:0]         f_valid_reg;
    logic                  f_cmd_reg  [FS];
    logic                  f_oor_reg  [FS];
    logic [23:0]           f_mos_reg  [FS];
    mtga_pkg::tile_num_t   f_tile_reg [FS];
    logic [7:0]            f_xw_reg   [FS];
    logic [7:0]            f_yw_reg   [FS];
    logic [5:0]            f_xr_reg   [FS];
    logic [5:0]            f_yr_reg   [FS];
    logic [7:0]            f_xw_next  [FS];
    logic [7:0]            f_yw_next  [FS];
    logic [5:0]            f_xr_next  [FS];
    logic [5:0]            f_yr_next  [FS];

    // source address products
    logic                  p_valid_reg;
    logic                  p_cmd_reg;
    logic                  p_oor_reg;
    logic [23:0]           p_mos_reg;
    mtga_pkg::src_t        p_tmul_reg;
    logic [16:0]           p_symul_reg;
    logic [7:0]            p_sx_reg;
    logic [TB+mtga_pkg::DD_W-1:0] tmul_full;
    logic [16:0]           symul;

    mtga_pkg::src_t        src_sum;
    logic                  map_ok;
    mtga_pkg::res_t        res;
    mtga_pkg::res_t        out_res;

    mtga_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign adv      = !skid_full;
    assign in_stall = skid_full;

    always_comb
    begin
        if (p0_cmd_reg == mtga_pkg::CMD_LOAD)
            a_oor_next = ({1'b0, p0_slot_reg} >= cfg.cells)
                      || (int'(p0_slot_reg) >= mtga_pkg::MAX_CELLS);
        else
            a_oor_next = ({1'b0, p0_x_reg} >= cfg.side) || ({1'b0, p0_y_reg} >= cfg.side);
        mos_prod = {13'd0, p0_y_reg} * {12'd0, cfg.side};
    end

    always_comb
    begin
        logic [11:0]     xw_in;
        logic [11:0]     yw_in;
        logic [5:0]      xr_in;
        logic [5:0]      yr_in;
        mtga_pkg::step_t sx;
        mtga_pkg::step_t sy;
        for (int k = 0; k < DS; k++)
        begin
            if (k == 0)
            begin
                xw_in = a_x_reg;
                yw_in = a_y_reg;
                xr_in = 6'd0;
                yr_in = 6'd0;
            end
            else
            begin
                xw_in = d_xw_reg[k-1];
                yw_in = d_yw_reg[k-1];
                xr_in = d_xr_reg[k-1];
                yr_in = d_yr_reg[k-1];
            end
            sx = mtga_pkg::div_step(xr_in, xw_in[11], cfg.stile);
            sy = mtga_pkg::div_step(yr_in, yw_in[11], cfg.stile);
            d_xw_next[k] = {xw_in[10:0], sx.q};
            d_yw_next[k] = {yw_in[10:0], sy.q};
            d_xr_next[k] = sx.rem;
            d_yr_next[k] = sy.rem;
        end
    end

    always_comb
    begin
        qx          = d_xw_reg[DS-1][mtga_pkg::GQ_W-1:0];
        qy          = d_yw_reg[DS-1][mtga_pkg::GQ_W-1:0];
        c_cell_next = {7'd0, qy} * {6'd0, cfg.grid} + {7'd0, qx};
        c_px_next   = {8'd0, d_xr_reg[DS-1]} * {5'd0, cfg.dtile};
        c_py_next   = {8'd0, d_yr_reg[DS-1]} * {5'd0, cfg.dtile};
    end

    assign ram_we   = c_valid_reg && (c_cmd_reg == mtga_pkg::CMD_LOAD) && !c_oor_reg;
    assign ram_addr = ram_we ? mtga_pkg::cell_addr_t'(c_slot_reg)
                             : mtga_pkg::cell_addr_t'(c_cell_reg);

    mtga_order_ram #(
        .DEPTH (mtga_pkg::MAX_CELLS),
        .WIDTH (TB)
    ) u_order_ram (
        .clk   (clk),
        .en    (adv),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (c_tile_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        logic [7:0]      xw_in;
        logic [7:0]      yw_in;
        logic [5:0]      xr_in;
        logic [5:0]      yr_in;
        mtga_pkg::step_t sx;
        mtga_pkg::step_t sy;
        for (int k = 0; k < FS; k++)
        begin
            if (k == 0)
            begin
                xw_in = m_px_reg[7:0];
                yw_in = m_py_reg[7:0];
                xr_in = m_px_reg[13:8];
                yr_in = m_py_reg[13:8];
            end
            else
            begin
                xw_in = f_xw_reg[k-1];
                yw_in = f_yw_reg[k-1];
                xr_in = f_xr_reg[k-1];
                yr_in = f_yr_reg[k-1];
            end
            sx = mtga_pkg::div_step(xr_in, xw_in[7], cfg.stile);
            sy = mtga_pkg::div_step(yr_in, yw_in[7], cfg.stile);
            f_xw_next[k] = {xw_in[6:0], sx.q};
            f_yw_next[k] = {yw_in[6:0], sy.q};
            f_xr_next[k] = sx.rem;
            f_yr_next[k] = sy.rem;
        end
    end

    assign tmul_full = {{mtga_pkg::DD_W{1'b0}}, f_tile_reg[FS-1]} * {{TB{1'b0}}, cfg.dd};
    assign symul     = {9'd0, f_yw_reg[FS-1]} * {8'd0, cfg.dtile};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_valid_reg <= 1'b0;
            a_valid_reg  <= 1'b0;
            d_valid_reg  <= '0;
            c_valid_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
            f_valid_reg  <= '0;
            p_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            p0_valid_reg <= in_valid;
            a_valid_reg  <= p0_valid_reg;
            d_valid_reg  <= {d_valid_reg[DS-2:0], a_valid_reg};
            c_valid_reg  <= d_valid_reg[DS-1];
            m_valid_reg  <= c_valid_reg;
            f_valid_reg  <= {f_valid_reg[FS-2:0], m_valid_reg};
            p_valid_reg  <= f_valid_reg[FS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p0_cmd_reg  <= cmd;
            p0_slot_reg <= order_slot;
            p0_tile_reg <= tile_number;
            p0_x_reg    <= out_x;
            p0_y_reg    <= out_y;

            a_cmd_reg  <= p0_cmd_reg;
            a_slot_reg <= p0_slot_reg;
            a_tile_reg <= mtga_pkg::tile_num_t'(p0_tile_reg);
            a_x_reg    <= p0_x_reg;
            a_y_reg    <= p0_y_reg;
            a_oor_reg  <= a_oor_next;
            a_mos_reg  <= mos_prod[23:0];

            for (int k = 0; k < DS; k++)
            begin
                d_xw_reg[k] <= d_xw_next[k];
                d_yw_reg[k] <= d_yw_next[k];
                d_xr_reg[k] <= d_xr_next[k];
                d_yr_reg[k] <= d_yr_next[k];
                if (k == 0)
                begin
                    d_cmd_reg[k]  <= a_cmd_reg;
                    d_oor_reg[k]  <= a_oor_reg;
                    d_slot_reg[k] <= a_slot_reg;
                    d_tile_reg[k] <= a_tile_reg;
                    d_mos_reg[k]  <= a_mos_reg + {12'd0, a_x_reg};
                end
                else
                begin
                    d_cmd_reg[k]  <= d_cmd_reg[k-1];
                    d_oor_reg[k]  <= d_oor_reg[k-1];
                    d_slot_reg[k] <= d_slot_reg[k-1];
                    d_tile_reg[k] <= d_tile_reg[k-1];
                    d_mos_reg[k]  <= d_mos_reg[k-1];
                end
            end

            c_cmd_reg  <= d_cmd_reg[DS-1];
            c_oor_reg  <= d_oor_reg[DS-1];
            c_slot_reg <= d_slot_reg[DS-1];
            c_tile_reg <= d_tile_reg[DS-1];
            c_mos_reg  <= d_mos_reg[DS-1];
            c_cell_reg <= c_cell_next;
            c_px_reg   <= c_px_next;
            c_py_reg   <= c_py_next;

            m_cmd_reg <= c_cmd_reg;
            m_oor_reg <= c_oor_reg
                      || ((c_cmd_reg == mtga_pkg::CMD_MAP)
                          && (int'(c_cell_reg) >= mtga_pkg::MAX_CELLS));
            m_mos_reg <= c_mos_reg;
            m_px_reg  <= c_px_reg;
            m_py_reg  <= c_py_reg;

            for (int k = 0; k < FS; k++)
            begin
                f_xw_reg[k] <= f_xw_next[k];
                f_yw_reg[k] <= f_yw_next[k];
                f_xr_reg[k] <= f_xr_next[k];
                f_yr_reg[k] <= f_yr_next[k];
                if (k == 0)
                begin
                    f_cmd_reg[k]  <= m_cmd_reg;
                    f_oor_reg[k]  <= m_oor_reg;
                    f_mos_reg[k]  <= m_mos_reg;
                    f_tile_reg[k] <= ram_rdata;
                end
                else
                begin
                    f_cmd_reg[k]  <= f_cmd_reg[k-1];
                    f_oor_reg[k]  <= f_oor_reg[k-1];
                    f_mos_reg[k]  <= f_mos_reg[k-1];
                    f_tile_reg[k] <= f_tile_reg[k-1];
                end
            end

            p_cmd_reg   <= f_cmd_reg[FS-1];
            p_oor_reg   <= f_oor_reg[FS-1];
            p_mos_reg   <= f_mos_reg[FS-1];
            p_tmul_reg  <= mtga_pkg::src_t'(tmul_full);
            p_symul_reg <= symul;
            p_sx_reg    <= f_xw_reg[FS-1];
        end
    end

    always_comb
    begin
        src_sum     = p_tmul_reg + mtga_pkg::src_t'(p_symul_reg) + mtga_pkg::src_t'(p_sx_reg);
        map_ok      = (p_cmd_reg == mtga_pkg::CMD_MAP) && !p_oor_reg;
        res.was_map = p_cmd_reg;
        res.oor     = p_oor_reg;
        res.src     = map_ok ? src_sum : '0;
        res.mos     = map_ok ? p_mos_reg : '0;
    end

    mtga_out_skid u_out_skid (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (p_valid_reg),
        .up_data    (res),
        .down_stall (out_stall),
        .out_valid  (out_valid),
        .out_data   (out_res),
        .full       (skid_full)
    );

    assign was_map        = out_res.was_map;
    assign source_address = out_res.src;
    assign mosaic_address = out_res.mos;
    assign out_of_range   = out_res.oor;

`ifndef ASSERT_OFF
    a_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (!was_map || out_of_range) |-> source_address == '0 && mosaic_address == '0)
        else $error("address not cleared on load acknowledge or out-of-range result");

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("skid entry occupied with no result on the output");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall))
        else $error("skid entry filled while the output was free");

    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall && !out_stall |=> !in_stall)
        else $error("skid entry did not drain when the output was taken");
`endif

endmodule

// ----- hw/rtl/mtga_cfg.sv -----
`timescale 1ns / 1ps
// Configuration registers with clamped and derived grid geometry.
module mtga_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mtga_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mtga_pkg::CFG_DATA_W-1:0]    cfg_data,
    output mtga_pkg::cfg_t                     cfg
);

    logic [6:0]  grid_side_reg;
    logic [6:0]  small_tile_reg;
    logic [8:0]  dataset_tile_reg;
    logic [6:0]  g_clamp;
    logic [6:0]  s_clamp;
    logic [8:0]  d_clamp;
    mtga_pkg::cfg_t cfg_reg;
    mtga_pkg::cfg_t cfg_next;
    logic        wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_side_reg    <= 7'd8;
            small_tile_reg   <= 7'd16;
            dataset_tile_reg <= 9'd16;
        end
        else if (wr)
        begin
            unique case (cfg_index)
                mtga_pkg::CFG_GRID_SIDE:    grid_side_reg    <= cfg_data[6:0];
                mtga_pkg::CFG_SMALL_TILE:   small_tile_reg   <= cfg_data[6:0];
                mtga_pkg::CFG_DATASET_TILE: dataset_tile_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (grid_side_reg == 7'd0)
            g_clamp = 7'd1;
        else if (grid_side_reg > 7'd64)
            g_clamp = 7'd64;
        else
            g_clamp = grid_side_reg;

        if (small_tile_reg == 7'd0)
            s_clamp = 7'd1;
        else if (small_tile_reg > 7'd64)
            s_clamp = 7'd64;
        else
            s_clamp = small_tile_reg;

        if (dataset_tile_reg == 9'd0)
            d_clamp = 9'd1;
        else if (dataset_tile_reg > 9'd256)
            d_clamp = 9'd256;
        else
            d_clamp = dataset_tile_reg;

        cfg_next.grid  = g_clamp;
        cfg_next.stile = s_clamp;
        cfg_next.dtile = d_clamp;
        cfg_next.cells = {6'd0, g_clamp} * {6'd0, g_clamp};
        cfg_next.side  = {6'd0, g_clamp} * {6'd0, s_clamp};
        cfg_next.dd    = {8'd0, d_clamp} * {8'd0, d_clamp};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grid  <= 7'd8;
            cfg_reg.stile <= 7'd16;
            cfg_reg.dtile <= 9'd16;
            cfg_reg.cells <= 13'd64;
            cfg_reg.side  <= 13'd128;
            cfg_reg.dd    <= 17'd256;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hw/rtl/mtga_order_ram.sv -----
`timescale 1ns / 1ps
// Single-port synchronous RAM with registered read data and clock enable.
module mtga_order_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 12
) (
    input  logic                                    clk,
    input  logic                                    en,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                        wdata,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem[addr] <= wdata;
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/mtga_out_skid.sv -----
`timescale 1ns / 1ps
// Output register with one skid entry that parts the pipeline from the result channel.
module mtga_out_skid (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           up_valid,
    input  mtga_pkg::res_t up_data,
    input  logic           down_stall,
    output logic           out_valid,
    output mtga_pkg::res_t out_data,
    output logic           full
);

    logic           out_valid_reg;
    logic           out_valid_next;
    logic           skid_valid_reg;
    logic           skid_valid_next;
    mtga_pkg::res_t out_data_reg;
    mtga_pkg::res_t skid_data_reg;
    logic           out_free;
    logic           take;

    assign out_free = !out_valid_reg || !down_stall;
    assign take     = up_valid && !skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = take;
            end
        end
        else if (take)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
            out_data_reg <= skid_valid_reg ? skid_data_reg : up_data;
        else if (take)
            skid_data_reg <= up_data;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign full      = skid_valid_reg;

endmodule
